FILE: hdl/nal_bit_rewriter_escape_insert_core_macros.svh
// assertion macros for the nal bit rewriter core
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef NAL_BIT_REWRITER_ESCAPE_INSERT_CORE_MACROS_SVH
`define NAL_BIT_REWRITER_ESCAPE_INSERT_CORE_MACROS_SVH

// same-cycle property, disabled during reset
`define NBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication from one cycle to the next, disabled during reset
`define NBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/nbr_pkg.sv
// shared types and constants for the nal bit rewriter
// no dependencies
package nbr_pkg;

  localparam int UE_VALUE_BITS = 16;
  localparam int OP_W          = 3;
  localparam int BYTE_W        = 8;
  localparam int COUNT_W       = 4;
  localparam int UE_W          = 16;
  localparam int MAX_RAW_BITS  = 8;

  localparam int CHUNK_W     = 2 * UE_VALUE_BITS + 1;
  localparam int LEN_W       = $clog2(CHUNK_W + 1);
  localparam int TOP_W       = $clog2(UE_VALUE_BITS + 1);
  localparam int ACC_W       = CHUNK_W + 7;
  localparam int CNT_W       = $clog2(ACC_W + 1);
  localparam int MAX_RESULTS = 8;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h03;

  typedef enum logic [OP_W-1:0] {
    OP_RAW     = 3'd0,
    OP_PAYLOAD = 3'd1,
    OP_ALIGN   = 3'd2,
    OP_UE      = 3'd3,
    OP_FINISH  = 3'd4
  } op_e;

  // bit string left-aligned in bits, len valid bits
  typedef struct packed {
    logic [CHUNK_W-1:0] bits;
    logic [LEN_W-1:0]   len;
    logic               align;
    logic               finish;
  } chunk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic       ins_pending;
    logic [1:0] run;
  } back_status_t;

endpackage

FILE: hdl/nbr_item_if.sv
// input item channel of the nal bit rewriter
// depends on nbr_pkg
interface nbr_item_if;
  logic                         valid;
  logic                         ready;
  logic [nbr_pkg::OP_W-1:0]     op;
  logic [nbr_pkg::BYTE_W-1:0]   bits_value;
  logic [nbr_pkg::COUNT_W-1:0]  bit_count;
  logic [nbr_pkg::UE_W-1:0]     ue_value;

  modport source (output valid, output op, output bits_value, output bit_count,
                  output ue_value, input ready);
  modport sink (input valid, input op, input bits_value, input bit_count,
                input ue_value, output ready);
endinterface

FILE: hdl/nbr_byte_if.sv
// output byte channel of the nal bit rewriter
// depends on nbr_pkg
interface nbr_byte_if;
  logic                       valid;
  logic                       ready;
  logic [nbr_pkg::BYTE_W-1:0] out_byte;
  logic                       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

FILE: hdl/nbr_front.sv
// front end: accepts items and turns each into a left-aligned bit string
// depends on nbr_pkg and nbr_item_if
module nbr_front (
  nbr_item_if.sink          item_i,
  input  logic              escape_enable_i,
  input  logic              q_ready_i,
  output logic              q_push_o,
  output nbr_pkg::chunk_t   q_data_o
);

  logic                              needed;
  logic [nbr_pkg::COUNT_W-1:0]       n_raw;
  logic [nbr_pkg::UE_VALUE_BITS:0]   code;
  logic [nbr_pkg::TOP_W-1:0]         top;
  logic [2:0]                        low;
  logic [nbr_pkg::CHUNK_W-1:0]       bv_ext;

  assign item_i.ready = q_ready_i;
  assign q_push_o     = item_i.valid && q_ready_i && needed;
  assign bv_ext       = nbr_pkg::CHUNK_W'(item_i.bits_value);

  // code for exp-golomb and its leading one
  always_comb begin
    code = {1'b0, nbr_pkg::UE_VALUE_BITS'(item_i.ue_value)} + 1'b1;
    top  = '0;
    for (int i = 0; i <= nbr_pkg::UE_VALUE_BITS; i++) begin
      if (code[i]) top = nbr_pkg::TOP_W'(i);
    end
  end

  // lowest set bit of the final original byte
  always_comb begin
    low = '0;
    for (int i = nbr_pkg::BYTE_W - 1; i >= 0; i--) begin
      if (item_i.bits_value[i]) low = 3'(i);
    end
  end

  always_comb begin
    n_raw = (item_i.bit_count > nbr_pkg::COUNT_W'(nbr_pkg::MAX_RAW_BITS))
          ? nbr_pkg::COUNT_W'(nbr_pkg::MAX_RAW_BITS) : item_i.bit_count;
    needed   = 1'b0;
    q_data_o = '0;
    unique case (nbr_pkg::op_e'(item_i.op))
      nbr_pkg::OP_RAW: begin
        needed        = (n_raw != '0);
        q_data_o.bits = bv_ext << (nbr_pkg::LEN_W'(nbr_pkg::CHUNK_W) - nbr_pkg::LEN_W'(n_raw));
        q_data_o.len  = nbr_pkg::LEN_W'(n_raw);
      end
      nbr_pkg::OP_PAYLOAD: begin
        needed        = !(escape_enable_i && item_i.bits_value == nbr_pkg::ESC_BYTE);
        q_data_o.bits = bv_ext << (nbr_pkg::CHUNK_W - nbr_pkg::BYTE_W);
        q_data_o.len  = nbr_pkg::LEN_W'(nbr_pkg::BYTE_W);
      end
      nbr_pkg::OP_ALIGN: begin
        needed         = 1'b1;
        q_data_o.bits  = {1'b1, {(nbr_pkg::CHUNK_W - 1){1'b0}}};
        q_data_o.len   = nbr_pkg::LEN_W'(1);
        q_data_o.align = 1'b1;
      end
      nbr_pkg::OP_UE: begin
        needed        = 1'b1;
        q_data_o.bits = nbr_pkg::CHUNK_W'(code)
                      << (nbr_pkg::LEN_W'(2 * nbr_pkg::UE_VALUE_BITS)
                          - nbr_pkg::LEN_W'({top, 1'b0}));
        q_data_o.len  = nbr_pkg::LEN_W'({top, 1'b1});
      end
      nbr_pkg::OP_FINISH: begin
        // kept bits above the old stop bit followed by the new one are bv[7:low]
        needed          = 1'b1;
        q_data_o.align  = 1'b1;
        q_data_o.finish = 1'b1;
        if (item_i.bits_value != '0) begin
          q_data_o.bits = bv_ext << (nbr_pkg::CHUNK_W - nbr_pkg::BYTE_W);
          q_data_o.len  = nbr_pkg::LEN_W'(nbr_pkg::BYTE_W) - nbr_pkg::LEN_W'(low);
        end else begin
          q_data_o.bits = {1'b1, {(nbr_pkg::CHUNK_W - 1){1'b0}}};
          q_data_o.len  = nbr_pkg::LEN_W'(1);
        end
      end
      default: begin
        needed = 1'b0;
      end
    endcase
  end

endmodule

FILE: hdl/nbr_queue.sv
// short queue of bit strings between front and back
// depends on nbr_pkg
module nbr_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  nbr_pkg::chunk_t         push_data_i,
  input  logic                    pop_i,
  output nbr_pkg::chunk_t         head_o,
  output logic                    head_valid_o,
  output nbr_pkg::queue_status_t  status_o
);

  nbr_pkg::chunk_t              mem_q [nbr_pkg::QUEUE_DEPTH];
  logic [nbr_pkg::QPTR_W:0]     wr_q, wr_d, rd_q, rd_d;
  logic                         full, empty;

  assign empty        = (wr_q == rd_q);
  assign full         = (wr_q[nbr_pkg::QPTR_W] != rd_q[nbr_pkg::QPTR_W])
                     && (wr_q[nbr_pkg::QPTR_W-1:0] == rd_q[nbr_pkg::QPTR_W-1:0]);
  assign head_o       = mem_q[rd_q[nbr_pkg::QPTR_W-1:0]];
  assign head_valid_o = !empty;
  assign status_o     = '{full: full, empty: empty};

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push_i && !full) wr_d = wr_q + 1'b1;
    if (pop_i && !empty) rd_d = rd_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full) mem_q[wr_q[nbr_pkg::QPTR_W-1:0]] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

endmodule

FILE: hdl/nbr_back.sv
// back end: packs bit strings into bytes, inserts escape bytes, drives output
// depends on nbr_pkg and nbr_byte_if
module nbr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   escape_enable_i,
  input  nbr_pkg::chunk_t        head_i,
  input  logic                   head_valid_i,
  output logic                   head_pop_o,
  nbr_byte_if.source             byte_o,
  output nbr_pkg::back_status_t  status_o
);

  logic [nbr_pkg::ACC_W-1:0]   acc_q, acc_d, m_acc, shifted;
  logic [nbr_pkg::CNT_W-1:0]   cnt_q, cnt_d, m_cnt;
  logic [nbr_pkg::CNT_W:0]     sum, sum_p7;
  logic [nbr_pkg::RES_W-1:0]   res_q, res_d, res_base;
  logic [1:0]                  run_q, run_d, run_inc;
  logic                        ins_q, ins_d;
  logic                        fin_q, fin_d, fin_cur;
  logic                        out_valid_q, out_valid_d;
  logic [nbr_pkg::BYTE_W-1:0]  out_byte_q, out_byte_d, cur_byte;
  logic                        out_last_q, out_last_d;
  logic                        can_emit, load, emit_byte, step, keep;

  assign byte_o.valid    = out_valid_q;
  assign byte_o.out_byte = out_byte_q;
  assign byte_o.last     = out_last_q;
  assign status_o        = '{ins_pending: ins_q, run: run_q};
  assign head_pop_o      = load && step;

  always_comb begin
    can_emit = !out_valid_q || byte_o.ready;
    load     = !ins_q && (cnt_q < nbr_pkg::CNT_W'(8)) && head_valid_i;
    shifted  = {head_i.bits, 7'b0} >> cnt_q[2:0];
    sum      = (nbr_pkg::CNT_W + 1)'(cnt_q) + (nbr_pkg::CNT_W + 1)'(head_i.len);
    sum_p7   = sum + (nbr_pkg::CNT_W + 1)'(7);
    // alignment pads with zeros up to the next byte boundary
    if (head_i.align) sum = {sum_p7[nbr_pkg::CNT_W:3], 3'b000};
    m_acc     = load ? (acc_q | shifted) : acc_q;
    m_cnt     = load ? nbr_pkg::CNT_W'(sum) : cnt_q;
    fin_cur   = load ? head_i.finish : fin_q;
    res_base  = load ? '0 : res_q;
    emit_byte = !ins_q && (m_cnt >= nbr_pkg::CNT_W'(8));
    step      = (ins_q || emit_byte) ? can_emit : load;
    keep      = res_base < nbr_pkg::RES_W'(nbr_pkg::MAX_RESULTS);
    cur_byte  = m_acc[nbr_pkg::ACC_W-1 -: nbr_pkg::BYTE_W];
    run_inc   = (run_q == 2'd2) ? 2'd2 : run_q + 2'd1;

    acc_d       = acc_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    run_d       = run_q;
    ins_d       = ins_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q && !byte_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (step) begin
      fin_d = fin_cur;
      if (ins_q) begin
        ins_d       = 1'b0;
        out_valid_d = keep;
        out_byte_d  = nbr_pkg::ESC_BYTE;
        out_last_d  = 1'b0;
        res_d       = keep ? res_base + 1'b1 : res_base;
      end else if (emit_byte) begin
        acc_d       = m_acc << nbr_pkg::BYTE_W;
        cnt_d       = m_cnt - nbr_pkg::CNT_W'(8);
        out_valid_d = keep;
        out_byte_d  = cur_byte;
        out_last_d  = fin_cur && (m_cnt == nbr_pkg::CNT_W'(8));
        res_d       = keep ? res_base + 1'b1 : res_base;
        if (cur_byte == '0) begin
          if (escape_enable_i && run_inc == 2'd2) begin
            ins_d = 1'b1;
            run_d = 2'd0;
          end else begin
            run_d = run_inc;
          end
        end else begin
          run_d = 2'd0;
        end
      end else begin
        acc_d = m_acc;
        cnt_d = m_cnt;
        res_d = res_base;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      res_q       <= '0;
      run_q       <= '0;
      ins_q       <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      res_q       <= res_d;
      run_q       <= run_d;
      ins_q       <= ins_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/nal_bit_rewriter_escape_insert_core.sv
// Rebuilds a NAL unit from a stream of items (raw bits, payload bytes, byte
// alignment, unsigned Exp-Golomb values, finish) and emits its bytes most
// significant bit first, inserting 0x03 after two zero bytes when escaping is
// on. An item is taken in every cycle while the four-entry queue between the
// front and the back end has room; the back end turns queued bit strings into
// bytes at one byte per cycle while the output accepts them; each inserted
// 0x03 takes an output slot of its own, and an item that completes no byte
// still takes a back-end step. Bytes pass the queue and an output register.
// Depends on nbr_pkg, nbr_item_if, nbr_byte_if, nbr_front, nbr_queue, nbr_back.
`include "nal_bit_rewriter_escape_insert_core_macros.svh"

module nal_bit_rewriter_escape_insert_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  nbr_item_if.sink    item_i,
  nbr_byte_if.source  byte_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  logic                   escape_enable_q;
  logic                   q_push, q_pop, q_head_valid;
  nbr_pkg::chunk_t        q_data, q_head;
  nbr_pkg::queue_status_t q_status;
  nbr_pkg::back_status_t  b_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      escape_enable_q <= cfg_wdata_i;
    end
  end

  nbr_front u_front (
    .item_i          (item_i),
    .escape_enable_i (escape_enable_q),
    .q_ready_i       (!q_status.full),
    .q_push_o        (q_push),
    .q_data_o        (q_data)
  );

  nbr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  (q_data),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .head_valid_o (q_head_valid),
    .status_o     (q_status)
  );

  nbr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .escape_enable_i (escape_enable_q),
    .head_i          (q_head),
    .head_valid_i    (q_head_valid),
    .head_pop_o      (q_pop),
    .byte_o          (byte_o),
    .status_o        (b_status)
  );

  // final byte always carries the stop bit
  `NBR_ASSERT(a_last_nonzero, !(byte_o.valid && byte_o.last) || (byte_o.out_byte != 8'h00), "last byte without stop bit")
  // an escape is pending only right after the zero run was consumed
  `NBR_ASSERT(a_ins_run_clear, !b_status.ins_pending || (b_status.run == 2'd0), "escape pending with live zero run")
  `NBR_ASSERT(a_queue_sane, !(q_status.full && q_status.empty), "queue full and empty")
  // a pending escape goes out on the next free output slot
  `NBR_ASSERT_NEXT(a_ins_drain, b_status.ins_pending && (!byte_o.valid || byte_o.ready), !b_status.ins_pending, "escape not issued")

endmodule
